// ----- rtl/mclim_pkg.sv -----
package mclim_pkg;

  localparam int PWM_W    = 9;
  localparam int MAG_W    = 8;
  localparam int SAMPLE_W = 10;
  localparam int CNT_W    = 16;
  localparam int MODE_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int LIMIT_DIVISOR_DEF = 4;

  // register map
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_WINDOW   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_HOLD   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPIKE_WINDOW = 2'd3;

  // reset values of the registers
  localparam logic [SAMPLE_W-1:0] THRESHOLD_RST    = 10'd100;
  localparam logic [CNT_W-1:0]    MAX_WINDOW_RST   = 16'd100;
  localparam logic [CNT_W-1:0]    LIMIT_HOLD_RST   = 16'd1000;
  localparam logic [CNT_W-1:0]    SPIKE_WINDOW_RST = 16'd100;
  // (SPIKE_WINDOW_RST / 100) * 99
  localparam logic [CNT_W-1:0]    SPIKE_THR_RST    = 16'd99;

  // floor(2^22 / 100): estimate of x / 100 for 16-bit x, low by at most one
  localparam logic [CNT_W-1:0] RECIP_100 = 16'd41943;
  localparam int               RECIP_100_SHIFT = 22;

  // limiter mode codes as seen on the output
  localparam logic [MODE_W-1:0] MODE_STANDARD = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CAUGHT   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LIMIT    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SPIKE    = 2'd3;

  typedef enum logic [3:0] {
    ST_STANDARD = 4'b0001,
    ST_CAUGHT   = 4'b0010,
    ST_LIMIT    = 4'b0100,
    ST_SPIKE    = 4'b1000
  } state_t;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? CNT_MAX : v + 1'b1;
  endfunction

  function automatic logic [MODE_W-1:0] mode_code(input state_t s);
    logic [MODE_W-1:0] code;
    unique case (s)
      ST_STANDARD: code = MODE_STANDARD;
      ST_CAUGHT:   code = MODE_CAUGHT;
      ST_LIMIT:    code = MODE_LIMIT;
      ST_SPIKE:    code = MODE_SPIKE;
      default:     code = MODE_STANDARD;
    endcase
    return code;
  endfunction

endpackage

// ----- rtl/motor_current_limiter_fsm.sv -----
// Motor current limiter, one control tick per transaction.
//
// Input channel (in_valid/in_ready): target_pwm (signed duty) and
// current_sample for one tick. Output channel (out_valid/out_ready):
// drive_pwm (limited duty, sign kept) and limiter_mode (0 standard,
// 1 caught max, 2 limit, 3 spike, the mode after this tick).
// Config port: cfg_write/cfg_index/cfg_data; the user must write it only
// while no transaction is in flight, which the block does not enforce.
//
// A transaction accepted into the input register has its result computed
// there and registered in the output register, raising out_valid, once
// that register is free. Throughput is one transaction per cycle while
// the receiver does not stall: the per-tick update is a few compares and
// counter steps between the input register and the output register.
// If the receiver stalls, the output register holds and the input
// register can still take one more transaction; after that in_ready drops
// until out_ready returns. Nothing is dropped.
// Reset: mode returns to standard, all counters clear, registers take
// their reset values (threshold 100, windows 100, hold 1000).
module motor_current_limiter_fsm
  import mclim_pkg::*;
#(
  parameter int LIMIT_DIVISOR = LIMIT_DIVISOR_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // input channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [PWM_W-1:0]      target_pwm,
  input  logic        [SAMPLE_W-1:0]   current_sample,
  // output channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [PWM_W-1:0]      drive_pwm,
  output logic        [MODE_W-1:0]     limiter_mode,
  // config write port
  input  logic                         cfg_write,
  input  logic        [CFG_IDX_W-1:0]  cfg_index,
  input  logic        [CFG_DATA_W-1:0] cfg_data
);

  // ceil(2^16 / d): exact quotient for any 8-bit magnitude and d in 1..16
  localparam int          RECIP_SHIFT = 16;
  localparam int          RECIP_W     = RECIP_SHIFT + 1;
  localparam int          RECIP_INT   =
    ((1 << RECIP_SHIFT) + LIMIT_DIVISOR - 1) / LIMIT_DIVISOR;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_INT);
  localparam int          QPROD_W     = MAG_W + RECIP_W;

  // configuration registers
  logic [SAMPLE_W-1:0] thr_level;
  logic [CNT_W-1:0]    max_window;
  logic [CNT_W-1:0]    limit_hold;
  logic [CNT_W-1:0]    spike_window;
  logic [CNT_W-1:0]    spike_thr;     // (spike_window / 100) * 99

  // limiter state
  state_t              state, state_next;
  logic [CNT_W-1:0]    over_count, over_count_next;
  logic [CNT_W-1:0]    caught_ticks, caught_ticks_next;
  logic [CNT_W-1:0]    limit_ticks, limit_ticks_next;
  logic [CNT_W-1:0]    spike_ticks, spike_ticks_next;
  logic [CNT_W-1:0]    under_count, under_count_next;

  // input register
  logic                s1_valid;
  logic signed [PWM_W-1:0]  s1_target;
  logic [SAMPLE_W-1:0] s1_sample;

  logic advance;   // output register free to take a result
  logic fire;      // tick processed this cycle

  assign advance  = !out_valid || out_ready;
  assign fire     = s1_valid && advance;
  assign in_ready = !s1_valid || advance;

  // ---------------------------------------------------------------
  // Spike threshold precompute on write: q = x/100 via reciprocal
  // estimate plus one correction, then q*99 = q*100 - q.
  // ---------------------------------------------------------------
  logic [31:0]         wq_prod;
  logic [9:0]          q_est;
  logic [16:0]         p100;
  logic [16:0]         rem100;
  logic                q_fix;
  logic [16:0]         p100_fix;
  logic [9:0]          q_div;
  logic [CNT_W-1:0]    thr_new;

  always_comb begin
    wq_prod  = cfg_data * RECIP_100;
    q_est    = wq_prod[31:RECIP_100_SHIFT];
    p100     = {1'b0, q_est, 6'b0} + {2'b0, q_est, 5'b0} + {5'b0, q_est, 2'b0};
    rem100   = {1'b0, cfg_data} - p100;
    q_fix    = (rem100 >= 17'd100);
    q_div    = q_est + {9'b0, q_fix};
    p100_fix = p100 + (q_fix ? 17'd100 : 17'd0);
    thr_new  = CNT_W'(p100_fix - {7'b0, q_div});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thr_level    <= THRESHOLD_RST;
      max_window   <= MAX_WINDOW_RST;
      limit_hold   <= LIMIT_HOLD_RST;
      spike_window <= SPIKE_WINDOW_RST;
      spike_thr    <= SPIKE_THR_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_THRESHOLD:  thr_level  <= cfg_data[SAMPLE_W-1:0];
        REG_MAX_WINDOW: max_window <= cfg_data;
        REG_LIMIT_HOLD: limit_hold <= cfg_data;
        REG_SPIKE_WINDOW: begin
          spike_window <= cfg_data;
          spike_thr    <= thr_new;
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_target <= target_pwm;
      s1_sample <= current_sample;
    end
  end

  // ---------------------------------------------------------------
  // Magnitude, limiting divide, sign restore
  // ---------------------------------------------------------------
  logic                neg;
  logic [PWM_W-1:0]    mag_full;   // 0..256
  logic [MAG_W-1:0]    mag;
  logic [QPROD_W-1:0]  qprod;
  logic [MAG_W-1:0]    mag_div;
  logic [MAG_W-1:0]    mag_out;
  logic [PWM_W-1:0]    drive_calc;
  logic                over, under;

  always_comb begin
    neg      = s1_target[PWM_W-1];
    mag_full = neg ? PWM_W'(-s1_target) : PWM_W'(s1_target);
    mag      = mag_full[PWM_W-1] ? {MAG_W{1'b1}} : mag_full[MAG_W-1:0];
    qprod    = mag * RECIP;
    mag_div  = qprod[RECIP_SHIFT +: MAG_W];
    mag_out  = (state == ST_LIMIT) ? mag_div : mag;
    drive_calc = neg ? PWM_W'(-{1'b0, mag_out}) : {1'b0, mag_out};
    over     = s1_sample > thr_level;
    under    = s1_sample < thr_level;
  end

  // ---------------------------------------------------------------
  // Mode and counter update, same order as the tick definition
  // ---------------------------------------------------------------
  logic [CNT_W-1:0] over_base;

  always_comb begin
    state_next        = state;
    over_count_next   = over_count;
    caught_ticks_next = caught_ticks;
    limit_ticks_next  = limit_ticks;
    spike_ticks_next  = spike_ticks;
    under_count_next  = under_count;
    over_base         = over_count;

    unique case (state)
      ST_STANDARD: begin
        if (over) begin
          state_next = ST_CAUGHT;
        end else if (over_count != '0) begin
          over_count_next = over_count - 1'b1;
        end
      end
      ST_CAUGHT: begin
        // window decision first, then this tick's sample is counted
        if (caught_ticks > max_window) begin
          if (over_count >= (spike_window >> 1)) begin
            over_base  = '0;
            state_next = ST_LIMIT;
          end else begin
            state_next = ST_STANDARD;
          end
          caught_ticks_next = CNT_W'(1);
        end else begin
          caught_ticks_next = sat_inc(caught_ticks);
        end
        over_count_next = over ? sat_inc(over_base) : over_base;
      end
      ST_LIMIT: begin
        if (limit_ticks > limit_hold) begin
          limit_ticks_next = '0;
          state_next       = ST_SPIKE;
        end else begin
          limit_ticks_next = sat_inc(limit_ticks);
        end
      end
      ST_SPIKE: begin
        if (spike_ticks > spike_window) begin
          state_next       = (under_count >= spike_thr) ? ST_STANDARD : ST_LIMIT;
          under_count_next = '0;
          spike_ticks_next = '0;
        end else begin
          if (under) begin
            under_count_next = sat_inc(under_count);
          end
          spike_ticks_next = sat_inc(spike_ticks);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_STANDARD;
      over_count   <= '0;
      caught_ticks <= '0;
      limit_ticks  <= '0;
      spike_ticks  <= '0;
      under_count  <= '0;
    end else if (fire) begin
      state        <= state_next;
      over_count   <= over_count_next;
      caught_ticks <= caught_ticks_next;
      limit_ticks  <= limit_ticks_next;
      spike_ticks  <= spike_ticks_next;
      under_count  <= under_count_next;
    end
  end

  // ---------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      drive_pwm    <= drive_calc;
      limiter_mode <= mode_code(state_next);
    end
  end

  // ---------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------
  // a full input register behind a stalled output blocks new ticks
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while both stages are full and stalled");

  // limiter state only moves when a tick is processed
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !fire |=> ($stable(state) && $stable(over_count) && $stable(spike_ticks)))
    else $error("limiter state changed without a tick");

  // reported mode matches the current limiter state
  a_mode_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (limiter_mode == mode_code(state)))
    else $error("limiter_mode disagrees with the limiter state");

  // saturated magnitude never gives the most negative code
  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (drive_pwm != -(PWM_W'(1) <<< (PWM_W - 1))))
    else $error("drive_pwm out of range");

endmodule

// ----- dv/tb_motor_current_limiter_fsm.sv -----
`timescale 1ns / 1ps

module tb_motor_current_limiter_fsm;
  import mclim_pkg::*;

  // Divisor applied to the PWM magnitude in limit mode; the DUT is built
  // with the same value.
  localparam int DIVISOR = LIMIT_DIVISOR_DEF;

  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 125;
  // cycles with no transaction on either channel before giving up
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic signed [PWM_W-1:0]    pwm;
    logic        [SAMPLE_W-1:0] sample;
  } tick_in_t;

  typedef struct packed {
    logic signed [PWM_W-1:0]  pwm;
    logic        [MODE_W-1:0] mode;
  } tick_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                         in_valid       = 1'b0;
  logic                         in_ready;
  logic signed [PWM_W-1:0]      target_pwm     = '0;
  logic        [SAMPLE_W-1:0]   current_sample = '0;
  logic                         out_valid;
  logic                         out_ready      = 1'b0;
  logic signed [PWM_W-1:0]      drive_pwm;
  logic        [MODE_W-1:0]     limiter_mode;
  logic                         cfg_write      = 1'b0;
  logic        [CFG_IDX_W-1:0]  cfg_index      = '0;
  logic        [CFG_DATA_W-1:0] cfg_data       = '0;

  motor_current_limiter_fsm #(
    .LIMIT_DIVISOR  (DIVISOR)
  ) u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .target_pwm     (target_pwm),
    .current_sample (current_sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .drive_pwm      (drive_pwm),
    .limiter_mode   (limiter_mode),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Limiter state as the testbench sees it, plus its copy of the registers.
  // ---------------------------------------------------------------------
  logic [MODE_W-1:0]   lim_mode;
  logic [CNT_W-1:0]    over_cnt;
  logic [CNT_W-1:0]    caught_cnt;
  logic [CNT_W-1:0]    hold_cnt;
  logic [CNT_W-1:0]    spike_cnt;
  logic [CNT_W-1:0]    under_cnt;

  logic [SAMPLE_W-1:0] thr_cfg;
  logic [CNT_W-1:0]    max_win_cfg;
  logic [CNT_W-1:0]    hold_cfg;
  logic [CNT_W-1:0]    spike_win_cfg;

  tick_in_t  pend_q[$];      // ticks waiting for the driver
  tick_out_t drive_exp_q[$]; // predicted drive/mode, oldest first
  tick_in_t  next_in;
  tick_in_t  took_in;
  tick_out_t want;

  int unsigned n_sent;       // ticks handed to the driver
  int unsigned n_checked;    // results compared against a prediction
  int unsigned err_cnt;
  int unsigned stall_cycles;
  int          send_idle_pct;
  int          recv_idle_pct;

  // counters stick at all-ones instead of wrapping
  function automatic logic [CNT_W-1:0] cnt_bump(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  // One control tick: update the limiter state and return the drive.
  function automatic tick_out_t limiter_tick(input tick_in_t t);
    logic             neg;
    logic [PWM_W-1:0] mag;
    logic             over;
    logic             under;
    tick_out_t        r;
    neg = t.pwm[PWM_W-1];
    mag = t.pwm;
    if (neg) mag = '0 - mag;
    // -256 has no positive twin in 9 bits: clamp before any division
    if (mag > 9'd255) mag = 9'd255;
    // a sample right at the threshold is neither over nor under
    over  = t.sample > thr_cfg;
    under = t.sample < thr_cfg;

    case (lim_mode)
      MODE_STANDARD: begin
        if (over) lim_mode = MODE_CAUGHT;
        else if (over_cnt != '0) over_cnt = over_cnt - 1'b1;
      end
      MODE_CAUGHT: begin
        // decision first, then this tick's sample is still counted
        if (caught_cnt > max_win_cfg) begin
          if (over_cnt >= spike_win_cfg / 2) begin
            over_cnt = '0;
            lim_mode = MODE_LIMIT;
          end else begin
            lim_mode = MODE_STANDARD;
          end
          caught_cnt = '0;
        end
        if (over) over_cnt = cnt_bump(over_cnt);
        caught_cnt = cnt_bump(caught_cnt);
      end
      MODE_LIMIT: begin
        mag = mag / DIVISOR;
        if (hold_cnt > hold_cfg) begin
          hold_cnt = '0;
          lim_mode = MODE_SPIKE;
        end else begin
          hold_cnt = cnt_bump(hold_cnt);
        end
      end
      default: begin
        if (spike_cnt > spike_win_cfg) begin
          // back to standard only if nearly every trial tick was under
          if (under_cnt >= (spike_win_cfg / 100) * 99) lim_mode = MODE_STANDARD;
          else lim_mode = MODE_LIMIT;
          under_cnt = '0;
          spike_cnt = '0;
        end else begin
          if (under) under_cnt = cnt_bump(under_cnt);
          spike_cnt = cnt_bump(spike_cnt);
        end
      end
    endcase

    r.pwm  = neg ? ('0 - mag) : mag;
    r.mode = lim_mode;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Driver: holds a transaction until accepted, then maybe idles.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pend_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        next_in        = pend_q.pop_front();
        in_valid       <= 1'b1;
        target_pwm     <= next_in.pwm;
        current_sample <= next_in.sample;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // ---------------------------------------------------------------------
  // Monitor: check the output transaction first, then predict the input
  // transaction of the same edge (its result cannot appear before the
  // next edge).
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      lim_mode      = MODE_STANDARD;
      over_cnt      = '0;
      caught_cnt    = '0;
      hold_cnt      = '0;
      spike_cnt     = '0;
      under_cnt     = '0;
    end else begin
      if (out_valid && out_ready) begin
        if (drive_exp_q.size() == 0) begin
          err_cnt++;
          $display("%0t: result with nothing expected: drive_pwm %0d limiter_mode %0d",
                   $time, drive_pwm, limiter_mode);
        end else begin
          want = drive_exp_q.pop_front();
          n_checked++;
          if (drive_pwm !== want.pwm) begin
            err_cnt++;
            $display("%0t: drive_pwm mismatch: expected %0d actual %0d",
                     $time, $signed(want.pwm), drive_pwm);
          end
          if (limiter_mode !== want.mode) begin
            err_cnt++;
            $display("%0t: limiter_mode mismatch: expected %0d actual %0d",
                     $time, want.mode, limiter_mode);
          end
        end
      end
      if (in_valid && in_ready) begin
        took_in.pwm    = target_pwm;
        took_in.sample = current_sample;
        drive_exp_q.push_back(limiter_tick(took_in));
      end
    end
  end

  // watchdog: nothing moving on either channel for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  task automatic queue_tick(input int pwm, input int sample);
    tick_in_t t;
    t.pwm    = PWM_W'(pwm);
    t.sample = SAMPLE_W'(sample);
    pend_q.push_back(t);
    n_sent++;
  endtask

  // sender stays quiet until every predicted result has been checked
  task automatic wait_drained();
    do @(posedge clk); while (n_checked != n_sent);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(val);
    // block is idle, so the copy can follow right away
    case (idx)
      REG_THRESHOLD:    thr_cfg       = SAMPLE_W'(val);
      REG_MAX_WINDOW:   max_win_cfg   = CNT_W'(val);
      REG_LIMIT_HOLD:   hold_cfg      = CNT_W'(val);
      REG_SPIKE_WINDOW: spike_win_cfg = CNT_W'(val);
      default: ;
    endcase
  endtask

  task automatic set_config(input int thr, input int max_win, input int hold,
                            input int spike_win);
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_MAX_WINDOW, max_win);
    write_reg(REG_LIMIT_HOLD, hold);
    write_reg(REG_SPIKE_WINDOW, spike_win);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Random ticks in runs of over-heavy, mixed and under-heavy current, so
  // the window counters actually reach their decisions.
  task automatic queue_random(input int n);
    int run_left;
    int over_pct;
    int pick;
    int pwm;
    int sample;
    run_left = 0;
    over_pct = 50;
    for (int i = 0; i < n; i++) begin
      if (run_left == 0) begin
        run_left = $urandom_range(8, 80);
        case ($urandom_range(0, 2))
          0:       over_pct = 95;
          1:       over_pct = 50;
          default: over_pct = 5;
        endcase
      end
      run_left--;

      pick = $urandom_range(0, 15);
      case (pick)
        0:       pwm = -256;
        1:       pwm = 255;
        2:       pwm = -255;
        3:       pwm = 0;
        default: pwm = $urandom;
      endcase

      if ($urandom_range(0, 9) == 0) begin
        sample = int'(thr_cfg);
      end else if ($urandom_range(0, 99) < over_pct) begin
        sample = (thr_cfg == 10'd1023) ? int'(thr_cfg)
                                       : $urandom_range(thr_cfg + 1, 1023);
      end else begin
        sample = (thr_cfg == 10'd0) ? int'(thr_cfg)
                                    : $urandom_range(0, thr_cfg - 1);
      end
      queue_tick(pwm, sample);
    end
  endtask

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin
    int sw;
    send_idle_pct = 37;
    recv_idle_pct = 45;
    n_sent        = 0;
    thr_cfg       = THRESHOLD_RST;
    max_win_cfg   = MAX_WINDOW_RST;
    hold_cfg      = LIMIT_HOLD_RST;
    spike_win_cfg = SPIKE_WINDOW_RST;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset values of the registers, staying in standard
    queue_tick(5, 0);
    queue_tick(-256, 100);
    wait_drained();

    // Short windows so one directed pass walks every mode:
    // standard -> caught -> limit (incl. -256 and truncation to 0)
    // -> spike -> standard -> caught -> back to standard.
    set_config(100, 2, 2, 4);
    queue_tick(0, 0);
    queue_tick(255, 100);      // at threshold: not over
    queue_tick(-255, 99);
    queue_tick(-256, 101);     // enters caught, magnitude clamps to 255
    queue_tick(1, 1023);
    queue_tick(-1, 1023);
    queue_tick(3, 100);
    queue_tick(-256, 1023);    // window done, enough over: limit
    queue_tick(-256, 0);
    queue_tick(255, 500);
    queue_tick(-1, 0);         // -1 / 4 truncates to 0
    queue_tick(3, 0);          // hold done: spike
    queue_tick(-5, 0);
    queue_tick(100, 1023);
    queue_tick(7, 100);
    queue_tick(-7, 50);
    queue_tick(128, 0);
    queue_tick(-128, 0);       // trial done: standard
    queue_tick(0, 1023);
    queue_tick(10, 0);
    queue_tick(20, 0);
    queue_tick(30, 0);         // too few over: back to standard
    queue_tick(40, 0);
    queue_tick(-50, 0);
    queue_tick(255, 1023);

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      // receiver-heavy idling, then sender-heavy, then full rate
      if (ph < 4) begin
        send_idle_pct = 37;
        recv_idle_pct = 45;
      end else if (ph < 8) begin
        send_idle_pct = 45;
        recv_idle_pct = 37;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      case (ph)
        0: set_config(0, 0, 0, 0);
        1: set_config(1023, 16'hFFFE, 16'hFFFE, 16'hFFFE);
        2: set_config($urandom_range(0, 1023), $urandom_range(0, 65534),
                      $urandom_range(0, 65534), $urandom_range(0, 65534));
        default: begin
          if (ph % 2) begin
            // long trial windows: spike can fall back to limit
            sw = $urandom_range(100, 220);
            set_config($urandom_range(1, 1022), sw / 2 + $urandom_range(0, 10),
                       $urandom_range(0, 10), sw);
          end else begin
            set_config($urandom_range(1, 1022), $urandom_range(0, 8),
                       $urandom_range(0, 8), $urandom_range(0, 12));
          end
        end
      endcase

      if (ph == 6) begin
        // pause mid-phase until every result is back
        queue_random(PHASE_ITEMS / 2);
        wait_drained();
        queue_random(PHASE_ITEMS - PHASE_ITEMS / 2);
      end else begin
        queue_random(PHASE_ITEMS);
      end
    end

    wait_drained();
    // a few more cycles to catch any stray result
    repeat (4) @(posedge clk);
    if (err_cnt == 0 && drive_exp_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
